@@ src/byte_budget_lru_cache_top_defines.svh @@
// Assertion macros for the byte budget LRU cache.
// No dependencies; included by the top level.
`ifndef BYTE_BUDGET_LRU_CACHE_TOP_DEFINES_SVH
`define BYTE_BUDGET_LRU_CACHE_TOP_DEFINES_SVH
`ifndef SYNTH
`define BBL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BBL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/bblru_pkg.sv @@
// Shared types and codes for the byte budget LRU cache.
// No dependencies.
package bblru_pkg;
    localparam int BYTE_W   = 40;
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int EVC_W    = 7;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] ST_MISS      = 3'd0;
    localparam logic [2:0] ST_HIT       = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_PRESENT   = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;
    localparam logic [2:0] ST_INSERTED  = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    localparam logic [EVC_W-1:0] EVC_MAX = '1;

    typedef struct packed {
        logic [1:0]          mode;
        logic [KEY_W-1:0]    key_high;
        logic [KEY_W-1:0]    key_low;
        logic [BYTE_W-1:0]   entry_bytes;
        logic [HANDLE_W-1:0] value_handle;
    } t_in_word;

    typedef struct packed {
        logic [2:0]          status;
        logic [HANDLE_W-1:0] hit_handle;
        logic [EVC_W-1:0]    evicted_count;
        logic [BYTE_W-1:0]   bytes_in_use;
    } t_res_word;

    typedef struct packed {
        logic       latch;
        logic       match;
        logic       make_recent;
        logic       rd_hit;
        logic       evict;
        logic       insert;
        logic       clear;
        logic       out_en;
        logic       use_handle;
        logic [2:0] status;
    } t_ctl;

    typedef struct packed {
        logic       hit;
        logic [1:0] mode;
        logic       size_zero;
        logic       too_large;
        logic       need_evict;
    } t_sts;
endpackage

@@ src/bblru_ram.sv @@
// Generic single write, single read RAM with registered read data.
// No dependencies.
module bblru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/bblru_ctrl.sv @@
// Controller state machine for the byte budget LRU cache.
// Depends on bblru_pkg.
module bblru_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bblru_pkg::t_sts  i_sts,
    output bblru_pkg::t_ctl  o_ctl,
    output logic             o_busy
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_RDH    = 3'd3;
    localparam logic [2:0] S_EVCHK  = 3'd4;
    localparam logic [2:0] S_EVICT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_MATCH;
                end
            end
            S_MATCH: begin
                o_ctl.match = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                case (i_sts.mode)
                    bblru_pkg::MODE_LOOKUP: begin
                        if (i_sts.hit) begin
                            o_ctl.make_recent = 1'b1;
                            o_ctl.rd_hit      = 1'b1;
                            n_state           = S_RDH;
                        end else begin
                            o_ctl.out_en = 1'b1;
                            o_ctl.status = bblru_pkg::ST_MISS;
                        end
                    end
                    bblru_pkg::MODE_INSERT: begin
                        if (i_sts.size_zero) begin
                            o_ctl.out_en = 1'b1;
                            o_ctl.status = bblru_pkg::ST_EMPTY;
                        end else if (i_sts.hit) begin
                            o_ctl.make_recent = 1'b1;
                            o_ctl.out_en      = 1'b1;
                            o_ctl.status      = bblru_pkg::ST_PRESENT;
                        end else if (i_sts.too_large) begin
                            o_ctl.out_en = 1'b1;
                            o_ctl.status = bblru_pkg::ST_TOO_LARGE;
                        end else begin
                            n_state = S_EVCHK;
                        end
                    end
                    bblru_pkg::MODE_CLEAR: begin
                        o_ctl.clear  = 1'b1;
                        o_ctl.out_en = 1'b1;
                        o_ctl.status = bblru_pkg::ST_CLEARED;
                    end
                    default: begin
                        o_ctl.out_en = 1'b1;
                        o_ctl.status = bblru_pkg::ST_MISS;
                    end
                endcase
            end
            S_RDH: begin
                o_ctl.out_en     = 1'b1;
                o_ctl.use_handle = 1'b1;
                o_ctl.status     = bblru_pkg::ST_HIT;
                n_state          = S_IDLE;
            end
            S_EVCHK: begin
                if (i_sts.need_evict) begin
                    n_state = S_EVICT;
                end else begin
                    o_ctl.insert = 1'b1;
                    o_ctl.out_en = 1'b1;
                    o_ctl.status = bblru_pkg::ST_INSERTED;
                    n_state      = S_IDLE;
                end
            end
            S_EVICT: begin
                o_ctl.evict = 1'b1;
                n_state     = S_EVCHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

@@ src/bblru_datapath.sv @@
// Datapath: key cells, age ranks, byte accounting and size/handle RAM.
// Depends on bblru_pkg and bblru_ram.
module bblru_datapath #(
    parameter int ENTRIES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bblru_pkg::t_ctl                 i_ctl,
    input  bblru_pkg::t_in_word             i_word,
    input  logic                            i_cfg_we,
    input  logic [bblru_pkg::BYTE_W-1:0]    i_cfg_data,
    output bblru_pkg::t_sts                 o_sts,
    output bblru_pkg::t_res_word            o_res,
    output logic                            o_done
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int BW = bblru_pkg::BYTE_W;
    localparam int HW = bblru_pkg::HANDLE_W;
    localparam int EW = bblru_pkg::EVC_W;

    bblru_pkg::t_in_word              r_in;
    logic [ENTRIES-1:0]               r_valid;
    logic [bblru_pkg::KEY_W-1:0]      r_kh [ENTRIES];
    logic [bblru_pkg::KEY_W-1:0]      r_kl [ENTRIES];
    logic [IW-1:0]                    r_rank [ENTRIES];
    logic [BW-1:0]                    r_used;
    logic [BW-1:0]                    n_used;
    logic [BW-1:0]                    r_budget;
    logic [LW-1:0]                    r_live;
    logic                             r_hit;
    logic [IW-1:0]                    r_hit_idx;
    logic [IW-1:0]                    r_vic_idx;
    logic [EW-1:0]                    r_evc;
    bblru_pkg::t_res_word             r_res;
    logic                             r_done;

    logic [ENTRIES-1:0]               match;
    logic [IW-1:0]                    match_idx;
    logic [IW-1:0]                    vic_idx;
    logic [IW-1:0]                    free_idx;
    logic [IW-1:0]                    hit_rank;
    logic [BW:0]                      fit_sum;
    logic [BW+HW-1:0]                 ram_rdata;
    logic [BW-1:0]                    vic_bytes;

    always_comb begin
        match_idx = '0;
        vic_idx   = '0;
        free_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_kh[i] == r_in.key_high)
                       && (r_kl[i] == r_in.key_low);
            if (match[i]) begin
                match_idx = IW'(i);
            end
            if (r_valid[i] && (r_rank[i] == '0)) begin
                vic_idx = IW'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    assign hit_rank  = r_rank[r_hit_idx];
    assign fit_sum   = {1'b0, r_used} + {1'b0, r_in.entry_bytes};
    assign vic_bytes = ram_rdata[BW+HW-1:HW];

    assign o_sts.hit        = r_hit;
    assign o_sts.mode       = r_in.mode;
    assign o_sts.size_zero  = (r_in.entry_bytes == '0);
    assign o_sts.too_large  = (r_in.entry_bytes > r_budget);
    assign o_sts.need_evict = (r_live != '0)
        && ((fit_sum > {1'b0, r_budget}) || (r_live >= LW'(ENTRIES)));

    always_comb begin
        n_used = r_used;
        if (i_ctl.clear) begin
            n_used = '0;
        end else if (i_ctl.evict) begin
            n_used = r_used - vic_bytes;
        end else if (i_ctl.insert) begin
            n_used = r_used + r_in.entry_bytes;
        end
    end

    bblru_ram #(
        .WIDTH (BW + HW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.insert),
        .i_waddr (free_idx),
        .i_wdata ({r_in.entry_bytes, r_in.value_handle}),
        .i_raddr (i_ctl.rd_hit ? r_hit_idx : vic_idx),
        .o_rdata (ram_rdata)
    );

    // payload and cell registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_in <= i_word;
        end
        if (i_ctl.match) begin
            r_hit     <= |match;
            r_hit_idx <= match_idx;
        end
        r_vic_idx <= vic_idx;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_ctl.make_recent) begin
                if (IW'(i) == r_hit_idx) begin
                    r_rank[i] <= IW'(r_live - LW'(1));
                end else if (r_valid[i] && (r_rank[i] > hit_rank)) begin
                    r_rank[i] <= r_rank[i] - IW'(1);
                end
            end else if (i_ctl.evict) begin
                if (r_valid[i]) begin
                    r_rank[i] <= r_rank[i] - IW'(1);
                end
            end else if (i_ctl.insert && (IW'(i) == free_idx)) begin
                r_rank[i] <= IW'(r_live);
                r_kh[i]   <= r_in.key_high;
                r_kl[i]   <= r_in.key_low;
            end
        end
        if (i_ctl.out_en) begin
            r_res.status        <= i_ctl.status;
            r_res.hit_handle    <= i_ctl.use_handle ? ram_rdata[HW-1:0] : '0;
            r_res.evicted_count <= r_evc;
            r_res.bytes_in_use  <= n_used;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_used   <= '0;
            r_live   <= '0;
            r_budget <= '1;
            r_evc    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_ctl.out_en;
            r_used <= n_used;
            if (i_cfg_we) begin
                r_budget <= i_cfg_data;
            end
            if (i_ctl.latch) begin
                r_evc <= '0;
            end else if (i_ctl.evict && (r_evc != bblru_pkg::EVC_MAX)) begin
                r_evc <= r_evc + EW'(1);
            end
            if (i_ctl.clear) begin
                r_valid <= '0;
                r_live  <= '0;
            end else if (i_ctl.evict) begin
                r_valid[r_vic_idx] <= 1'b0;
                r_live             <= r_live - LW'(1);
            end else if (i_ctl.insert) begin
                r_valid[free_idx] <= 1'b1;
                r_live            <= r_live + LW'(1);
            end
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;
endmodule

@@ src/byte_budget_lru_cache_top.sv @@
// Top level of the byte budget LRU cache: controller, datapath, checks.
// Depends on bblru_pkg, bblru_ctrl, bblru_datapath and the defines header.
//
// Fully associative, size-aware LRU cache of ENTRIES slots keyed by a 128-bit
// hash. Pulse i_start while o_busy is low to hand over one command word
// (lookup, insert or clear); exactly one result word follows on o_res,
// with o_done high for a single cycle. The receiver cannot stall, so it must
// take the word in that cycle. A lookup miss, empty insert, present key,
// oversize insert or clear is answered from the decide state that follows
// the match; a lookup hit first does a registered read of the handle RAM;
// an insert of a new key loops through the eviction check, where each
// eviction reads the victim's size from the RAM before the byte total is
// updated. Key matching is done in parallel across all slots. o_busy
// stays high until the result cycle, so a new word can be sent in the cycle
// its predecessor's result appears. The byte budget is written through the
// cfg channel (always ready) and must only change while the cache is idle;
// lowering it evicts nothing until the next insert of a new key.
`include "byte_budget_lru_cache_top_defines.svh"
module byte_budget_lru_cache_top #(
    parameter int ENTRIES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  bblru_pkg::t_in_word           i_word,
    output logic                          o_done,
    output bblru_pkg::t_res_word          o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bblru_pkg::BYTE_W-1:0]  i_cfg_data
);
    bblru_pkg::t_ctl ctl;
    bblru_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    bblru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (o_busy)
    );

    bblru_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_word     (i_word),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_res      (o_res),
        .o_done     (o_done)
    );

    // a result only ever closes a word that was in flight
    `BBL_ASSERT_NOW(a_done_after_busy, i_clk, i_rst_n, o_done, $past(o_busy))
    // an accepted word keeps the block busy for its match cycle
    `BBL_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // handles only come back on hits
    `BBL_ASSERT_NOW(a_handle_hit, i_clk, i_rst_n,
        o_done && (o_res.status != bblru_pkg::ST_HIT), o_res.hit_handle == '0)
    // evictions only ever reported by an insert
    `BBL_ASSERT_NOW(a_evict_insert, i_clk, i_rst_n,
        o_done && (o_res.status != bblru_pkg::ST_INSERTED), o_res.evicted_count == '0)
endmodule
